### design/aabb_pkg.sv
package aabb_pkg;

    // table size and derived widths
    localparam int BOX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(BOX_ENTRIES);
    localparam int COORD_W     = 16;
    localparam int CAND_W      = COORD_W + 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [CAND_W-1:0]  t_cand;
    typedef logic [IDX_W-1:0]          t_idx;

    // one box table word
    typedef struct packed {
        t_coord min_x;
        t_coord min_y;
        t_coord min_z;
        t_coord max_x;
        t_coord max_y;
        t_coord max_z;
    } t_box;

    // item opcodes; code 3 is ignored
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_MOVE   = 2'd1,
        OP_SETPOS = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } t_state;

    // control from the sequencer to the checker
    typedef struct packed {
        logic clr;
        logic issue;
        logic ent_valid;
    } t_scan_ctl;

endpackage

### design/aabb_slide_collision.sv
// Box write and set-position items do not leave idle; busy stays low for them.
// A move item runs through ST_SCAN, ST_LAST and ST_DONE, and its result is then
// registered; busy holds off the next item until the block is back in idle: the box memory
// has one read port and the scan reads one entry per cycle.
// The receiver cannot stall; each result is on the ports for one cycle.
// Synchronous reset clears position, valid bits and control; box memory holds.
module aabb_slide_collision (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_op,
    input  logic [5:0]           i_entry_index,
    input  aabb_pkg::t_coord     i_min_x,
    input  aabb_pkg::t_coord     i_min_y,
    input  aabb_pkg::t_coord     i_min_z,
    input  aabb_pkg::t_coord     i_max_x,
    input  aabb_pkg::t_coord     i_max_y,
    input  aabb_pkg::t_coord     i_max_z,
    input  logic                 i_entry_valid,
    input  aabb_pkg::t_coord     i_delta_x,
    input  aabb_pkg::t_coord     i_delta_y,
    input  aabb_pkg::t_coord     i_delta_z,
    output logic                 o_valid,
    output aabb_pkg::t_coord     o_applied_dx,
    output aabb_pkg::t_coord     o_applied_dz,
    output aabb_pkg::t_coord     o_new_x,
    output aabb_pkg::t_coord     o_new_z,
    output logic                 o_x_blocked,
    output logic                 o_z_blocked
);
    import aabb_pkg::*;

    t_state r_state, n_state;
    t_idx   r_addr;
    logic   [BOX_ENTRIES-1:0] r_valid;
    t_coord r_pos_x, r_pos_y, r_pos_z;
    t_coord r_dx, r_dz;
    t_cand  r_cx, r_cy, r_cz;

    logic      r_out_valid;
    t_coord    r_out_dx, r_out_dz, r_out_x, r_out_z;
    logic      r_out_xb, r_out_zb;

    logic      accept;
    logic      wr_en;
    logic      rd_en;
    logic      last_addr;
    t_box      wr_box;
    t_box      rd_box;
    t_scan_ctl scan_ctl;
    logic      xb, zb;
    t_coord    app_dx, app_dz;

    assign accept    = start && !busy;
    assign last_addr = (r_addr == IDX_W'(BOX_ENTRIES - 1));
    assign wr_en     = accept && (i_op == OP_WRITE) &&
                       (32'(i_entry_index) < BOX_ENTRIES);

    always_comb begin
        wr_box.min_x = i_min_x;
        wr_box.min_y = i_min_y;
        wr_box.min_z = i_min_z;
        wr_box.max_x = i_max_x;
        wr_box.max_y = i_max_y;
        wr_box.max_z = i_max_z;
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_op == OP_MOVE)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_addr) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        busy               = 1'b1;
        rd_en              = 1'b0;
        scan_ctl.clr       = 1'b0;
        scan_ctl.issue     = 1'b0;
        scan_ctl.ent_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy         = 1'b0;
                scan_ctl.clr = accept && (i_op == OP_MOVE);
            end
            ST_SCAN: begin
                rd_en              = 1'b1;
                scan_ctl.issue     = 1'b1;
                scan_ctl.ent_valid = r_valid[r_addr];
            end
            ST_LAST: busy = 1'b1;
            ST_DONE: busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) begin
                r_addr <= r_addr + IDX_W'(1);
            end else begin
                r_addr <= '0;
            end
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[IDX_W'(i_entry_index)] <= i_entry_valid;
        end
    end

    // move operands: candidate is the exact 17-bit sum
    always_ff @(posedge i_clk) begin
        if (accept && (i_op == OP_MOVE)) begin
            r_dx <= i_delta_x;
            r_dz <= i_delta_z;
            r_cx <= t_cand'(r_pos_x) + t_cand'(i_delta_x);
            r_cy <= t_cand'(r_pos_y) + t_cand'(i_delta_y);
            r_cz <= t_cand'(r_pos_z) + t_cand'(i_delta_z);
        end
    end

    assign app_dx = xb ? '0 : r_dx;
    assign app_dz = zb ? '0 : r_dz;

    // position: set absolutely or advanced at the end of a move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
        end else if (accept && (i_op == OP_SETPOS)) begin
            r_pos_x <= i_delta_x;
            r_pos_y <= i_delta_y;
            r_pos_z <= i_delta_z;
        end else if (r_state == ST_DONE) begin
            r_pos_x <= r_pos_x + app_dx;
            r_pos_z <= r_pos_z + app_dz;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            r_out_dx <= app_dx;
            r_out_dz <= app_dz;
            r_out_x  <= r_pos_x + app_dx;
            r_out_z  <= r_pos_z + app_dz;
            r_out_xb <= xb;
            r_out_zb <= zb;
        end
    end

    aabb_box_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(i_entry_index)),
        .i_wr_data (wr_box),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_box)
    );

    aabb_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_box       (rd_box),
        .i_cx        (r_cx),
        .i_cy        (r_cy),
        .i_cz        (r_cz),
        .i_px        (r_pos_x),
        .i_py        (r_pos_y),
        .i_pz        (r_pos_z),
        .o_x_blocked (xb),
        .o_z_blocked (zb)
    );

    assign o_valid      = r_out_valid;
    assign o_applied_dx = r_out_dx;
    assign o_applied_dz = r_out_dz;
    assign o_new_x      = r_out_x;
    assign o_new_z      = r_out_z;
    assign o_x_blocked  = r_out_xb;
    assign o_z_blocked  = r_out_zb;

    // result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // a move item always starts a scan
    a_move_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_MOVE)) |=> (busy && r_state == ST_SCAN))
        else $error("move item did not start a scan");

    // a blocked axis reports a zero step
    a_blocked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_x_blocked) |-> (o_applied_dx == '0))
        else $error("x blocked but step nonzero");

    // scan finishes after the last table entry
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && last_addr) |=> (r_state == ST_LAST))
        else $error("scan did not end at last entry");

endmodule

### design/aabb_box_ram.sv
module aabb_box_ram (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  aabb_pkg::t_idx       i_wr_addr,
    input  aabb_pkg::t_box       i_wr_data,
    input  logic                 i_rd_en,
    input  aabb_pkg::t_idx       i_rd_addr,
    output aabb_pkg::t_box       o_rd_data
);
    import aabb_pkg::*;

    t_box r_mem [BOX_ENTRIES];
    t_box r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/aabb_scan.sv
module aabb_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aabb_pkg::t_scan_ctl  i_ctl,
    input  aabb_pkg::t_box       i_box,
    input  aabb_pkg::t_cand      i_cx,
    input  aabb_pkg::t_cand      i_cy,
    input  aabb_pkg::t_cand      i_cz,
    input  aabb_pkg::t_coord     i_px,
    input  aabb_pkg::t_coord     i_py,
    input  aabb_pkg::t_coord     i_pz,
    output logic                 o_x_blocked,
    output logic                 o_z_blocked
);
    import aabb_pkg::*;

    logic r_pend;
    logic r_vbit;
    logic r_xb, n_xb;
    logic r_zb, n_zb;

    logic cin_x, cin_y, cin_z;
    logic pin_x, pin_y, pin_z;
    logic hit;

    // strict open-interval test on one axis, 17-bit exact
    function automatic logic in_open(t_coord lo, t_coord hi, t_cand p);
        return (t_cand'(lo) < p) && (t_cand'(hi) > p);
    endfunction

    // these are registered alongside the read, so read data lines up with them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_vbit <= 1'b0;
        end else begin
            r_pend <= i_ctl.issue;
            r_vbit <= i_ctl.ent_valid;
        end
    end

    // per-axis containment of candidate and of current position
    always_comb begin
        cin_x = in_open(i_box.min_x, i_box.max_x, i_cx);
        cin_y = in_open(i_box.min_y, i_box.max_y, i_cy);
        cin_z = in_open(i_box.min_z, i_box.max_z, i_cz);
        pin_x = in_open(i_box.min_x, i_box.max_x, t_cand'(i_px));
        pin_y = in_open(i_box.min_y, i_box.max_y, t_cand'(i_py));
        pin_z = in_open(i_box.min_z, i_box.max_z, t_cand'(i_pz));
        hit   = r_pend && r_vbit && cin_x && cin_y && cin_z;
    end

    // blocked flags collect over the whole table
    always_comb begin
        n_xb = r_xb | (hit & cin_x & pin_y & pin_z);
        n_zb = r_zb | (hit & pin_x & pin_y & cin_z);
        if (i_ctl.clr) begin
            n_xb = 1'b0;
            n_zb = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xb <= 1'b0;
            r_zb <= 1'b0;
        end else begin
            r_xb <= n_xb;
            r_zb <= n_zb;
        end
    end

    assign o_x_blocked = r_xb;
    assign o_z_blocked = r_zb;

endmodule

### sim/aabb_slide_collision_chk.sv
`timescale 1ns / 100ps

// Watches the item and result channels of the box collision block, keeps its
// own copy of the box table and position, and checks every move result.
module aabb_slide_collision_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [1:0]        i_op,
    input  logic [5:0]        i_entry_index,
    input  aabb_pkg::t_coord  i_min_x,
    input  aabb_pkg::t_coord  i_min_y,
    input  aabb_pkg::t_coord  i_min_z,
    input  aabb_pkg::t_coord  i_max_x,
    input  aabb_pkg::t_coord  i_max_y,
    input  aabb_pkg::t_coord  i_max_z,
    input  logic              i_entry_valid,
    input  aabb_pkg::t_coord  i_delta_x,
    input  aabb_pkg::t_coord  i_delta_y,
    input  aabb_pkg::t_coord  i_delta_z,
    input  logic              i_res_valid,
    input  aabb_pkg::t_coord  i_applied_dx,
    input  aabb_pkg::t_coord  i_applied_dz,
    input  aabb_pkg::t_coord  i_new_x,
    input  aabb_pkg::t_coord  i_new_z,
    input  logic              i_x_blocked,
    input  logic              i_z_blocked,
    output int                o_errors,
    output int                o_pending,
    output int                o_moves,
    output int                o_x_stops,
    output int                o_z_stops
);
    import aabb_pkg::*;

    // expected outcome of one move item
    typedef struct packed {
        t_coord dx;
        t_coord dz;
        t_coord nx;
        t_coord nz;
        logic   xb;
        logic   zb;
    } t_move_res;

    t_box       box_tbl  [BOX_ENTRIES];
    logic       box_live [BOX_ENTRIES];
    t_coord     pos_x;
    t_coord     pos_y;
    t_coord     pos_z;
    t_move_res  move_q [$];
    t_move_res  want;
    int         err_count;
    int         n_moves;
    int         n_xstop;
    int         n_zstop;

    assign o_errors = err_count;

    initial begin
        err_count = 0;
        n_moves   = 0;
        n_xstop   = 0;
        n_zstop   = 0;
    end

    task automatic report(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic compare_field(string name, int got, int exp_val);
        if (got != exp_val) begin
            report($sformatf("%s got %0d, expected %0d", name, got, exp_val));
        end
    endtask

    // strict containment; the point is held at candidate width
    function automatic logic encloses(t_box b, t_cand px, t_cand py, t_cand pz);
        return ($signed(b.min_x) < px) && (px < $signed(b.max_x)) &&
               ($signed(b.min_y) < py) && (py < $signed(b.max_y)) &&
               ($signed(b.min_z) < pz) && (pz < $signed(b.max_z));
    endfunction

    // sliding response over all live boxes, then advance x and z
    task automatic predict_move(t_coord dx, t_coord dy, t_coord dz);
        t_cand     cx;
        t_cand     cy;
        t_cand     cz;
        logic      xb;
        logic      zb;
        t_move_res r;
        cx = pos_x + dx;
        cy = pos_y + dy;
        cz = pos_z + dz;
        xb = 1'b0;
        zb = 1'b0;
        for (int e = 0; e < BOX_ENTRIES; e++) begin
            if (box_live[e] && encloses(box_tbl[e], cx, cy, cz)) begin
                if (encloses(box_tbl[e], cx, pos_y, pos_z)) xb = 1'b1;
                if (encloses(box_tbl[e], pos_x, pos_y, cz)) zb = 1'b1;
            end
        end
        r.dx = xb ? t_coord'(0) : dx;
        r.dz = zb ? t_coord'(0) : dz;
        pos_x = pos_x + r.dx;
        pos_z = pos_z + r.dz;
        r.nx = pos_x;
        r.nz = pos_z;
        r.xb = xb;
        r.zb = zb;
        move_q.push_back(r);
    endtask

    // results first, then the item taken at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < BOX_ENTRIES; e++) box_live[e] = 1'b0;
            pos_x = '0;
            pos_y = '0;
            pos_z = '0;
            move_q.delete();
        end else begin
            if (i_res_valid) begin
                if (move_q.size() == 0) begin
                    report("move result with no move item pending");
                end else begin
                    want = move_q.pop_front();
                    n_moves++;
                    if (want.xb) n_xstop++;
                    if (want.zb) n_zstop++;
                    compare_field("applied_dx", $signed(i_applied_dx), $signed(want.dx));
                    compare_field("applied_dz", $signed(i_applied_dz), $signed(want.dz));
                    compare_field("new_x", $signed(i_new_x), $signed(want.nx));
                    compare_field("new_z", $signed(i_new_z), $signed(want.nz));
                    compare_field("x_blocked", i_x_blocked, want.xb);
                    compare_field("z_blocked", i_z_blocked, want.zb);
                end
            end
            if (i_start && !i_busy) begin
                case (i_op)
                    OP_WRITE: begin
                        box_tbl[i_entry_index]  = {i_min_x, i_min_y, i_min_z,
                                                   i_max_x, i_max_y, i_max_z};
                        box_live[i_entry_index] = i_entry_valid;
                    end
                    OP_SETPOS: begin
                        pos_x = i_delta_x;
                        pos_y = i_delta_y;
                        pos_z = i_delta_z;
                    end
                    OP_MOVE: begin
                        predict_move(i_delta_x, i_delta_y, i_delta_z);
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= move_q.size();
        o_moves   <= n_moves;
        o_x_stops <= n_xstop;
        o_z_stops <= n_zstop;
    end

endmodule

### sim/aabb_slide_collision_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the box collision block; checking lives in the
// checker instance.
module aabb_slide_collision_tb;
    import aabb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         WORLD     = 1024;
    localparam int         N_RANDOM  = 1680;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [5:0]  entry_index;
    t_coord      min_x, min_y, min_z;
    t_coord      max_x, max_y, max_z;
    logic        entry_valid;
    t_coord      delta_x, delta_y, delta_z;
    logic        res_valid;
    t_coord      applied_dx, applied_dz, new_x, new_z;
    logic        x_blocked, z_blocked;
    int          errors, pending, moves, x_stops, z_stops;
    int          n_items;

    aabb_slide_collision uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (op),
        .i_entry_index  (entry_index),
        .i_min_x        (min_x),
        .i_min_y        (min_y),
        .i_min_z        (min_z),
        .i_max_x        (max_x),
        .i_max_y        (max_y),
        .i_max_z        (max_z),
        .i_entry_valid  (entry_valid),
        .i_delta_x      (delta_x),
        .i_delta_y      (delta_y),
        .i_delta_z      (delta_z),
        .o_valid        (res_valid),
        .o_applied_dx   (applied_dx),
        .o_applied_dz   (applied_dz),
        .o_new_x        (new_x),
        .o_new_z        (new_z),
        .o_x_blocked    (x_blocked),
        .o_z_blocked    (z_blocked)
    );

    aabb_slide_collision_chk chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (op),
        .i_entry_index  (entry_index),
        .i_min_x        (min_x),
        .i_min_y        (min_y),
        .i_min_z        (min_z),
        .i_max_x        (max_x),
        .i_max_y        (max_y),
        .i_max_z        (max_z),
        .i_entry_valid  (entry_valid),
        .i_delta_x      (delta_x),
        .i_delta_y      (delta_y),
        .i_delta_z      (delta_z),
        .i_res_valid    (res_valid),
        .i_applied_dx   (applied_dx),
        .i_applied_dz   (applied_dz),
        .i_new_x        (new_x),
        .i_new_z        (new_z),
        .i_x_blocked    (x_blocked),
        .i_z_blocked    (z_blocked),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_moves        (moves),
        .o_x_stops      (x_stops),
        .o_z_stops      (z_stops)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop if the run hangs
    initial begin
        #4_000_000;
        $display("[aabb_slide_collision] ERROR");
        $finish;
    end

    // mostly back to back or short gaps, a few long ones, some bursts with none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((n_items / 128) % 3 == 2) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_item(logic [1:0] op_c, logic [5:0] idx, t_box b, logic v,
                             t_coord dx, t_coord dy, t_coord dz);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        op          <= op_c;
        entry_index <= idx;
        min_x       <= b.min_x;
        min_y       <= b.min_y;
        min_z       <= b.min_z;
        max_x       <= b.max_x;
        max_y       <= b.max_y;
        max_z       <= b.max_z;
        entry_valid <= v;
        delta_x     <= dx;
        delta_y     <= dy;
        delta_z     <= dz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_items++;
    endtask

    function automatic t_box rand_box();
        return {$urandom, $urandom, $urandom};
    endfunction

    function automatic t_box make_box(int cx, int cy, int cz, int hx, int hy, int hz);
        t_box b;
        b.min_x = t_coord'(cx - hx);
        b.min_y = t_coord'(cy - hy);
        b.min_z = t_coord'(cz - hz);
        b.max_x = t_coord'(cx + hx);
        b.max_y = t_coord'(cy + hy);
        b.max_z = t_coord'(cz + hz);
        return b;
    endfunction

    // unused fields of each op carry random bits
    task automatic put_box(int idx, t_box b, logic v);
        send_item(OP_WRITE, 6'(idx), b, v,
                  t_coord'($urandom), t_coord'($urandom), t_coord'($urandom));
    endtask

    task automatic set_pos(int x, int y, int z);
        send_item(OP_SETPOS, 6'($urandom), rand_box(), 1'($urandom),
                  t_coord'(x), t_coord'(y), t_coord'(z));
    endtask

    task automatic move(int dx, int dy, int dz);
        send_item(OP_MOVE, 6'($urandom), rand_box(), 1'($urandom),
                  t_coord'(dx), t_coord'(dy), t_coord'(dz));
    endtask

    function automatic int rand_span(int half);
        return $signed($urandom_range(0, 2 * half)) - half;
    endfunction

    initial begin
        t_box full_box;
        t_box cube;
        t_box flipped;
        int   r;
        n_items     = 0;
        full_box    = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        cube        = make_box(0, 0, 0, 160, 160, 160);
        flipped     = make_box(0, 0, 0, -100, -100, -100);
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        op          <= OP_WRITE;
        entry_index <= '0;
        min_x       <= '0;
        min_y       <= '0;
        min_z       <= '0;
        max_x       <= '0;
        max_y       <= '0;
        max_z       <= '0;
        entry_valid <= 1'b0;
        delta_x     <= '0;
        delta_y     <= '0;
        delta_z     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: extreme steps and position wrap
        move(16'sh7fff, 16'sh0000, 16'sh8000);
        move(16'sh0001, 16'sh0000, 16'shffff);
        set_pos(16'sh8000, 16'sh8000, 16'sh7fff);
        move(16'sh8000, 16'sh8000, 16'sh7fff);

        // one cube: x blocked, both blocked, corner entry, face contact, y offset
        put_box(0, cube, 1'b1);
        set_pos(-320, 0, 0);
        move(320, 0, 16);
        set_pos(0, 0, 0);
        move(16, 0, 16);
        set_pos(-320, 0, -320);
        move(320, 0, 320);
        set_pos(-320, 0, 0);
        move(160, 0, 0);
        set_pos(-320, 400, 0);
        move(320, -400, 0);

        // inverted box never blocks; a cleared entry drops out
        put_box(2, flipped, 1'b1);
        put_box(0, cube, 1'b0);
        set_pos(0, 0, 0);
        move(16, 0, 16);

        // full-range box: candidate past the 16-bit range must not wrap inside
        put_box(1, full_box, 1'b1);
        set_pos(32000, 0, -32000);
        move(16'sh7fff, 16, 16'sh8000);
        move(16, 0, 16);

        // unused code, then clear the wide entries
        send_item(OP_UNUSED, 6'($urandom), rand_box(), 1'($urandom),
                  t_coord'($urandom), t_coord'($urandom), t_coord'($urandom));
        put_box(63, full_box, 1'b0);
        put_box(1, full_box, 1'b0);

        // random walk among random boxes in a small world, with some noise
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_item(2'($urandom), 6'($urandom), rand_box(), 1'($urandom),
                          t_coord'($urandom), t_coord'($urandom), t_coord'($urandom));
            end else if (r < 14) begin
                put_box($urandom, make_box(rand_span(WORLD), rand_span(128), rand_span(WORLD),
                                           $urandom_range(16, 400), $urandom_range(64, 400),
                                           $urandom_range(16, 400)),
                        $urandom_range(0, 9) != 0);
            end else if (r < 20) begin
                set_pos(rand_span(WORLD), rand_span(64), rand_span(WORLD));
            end else if (r < 24) begin
                move($urandom, $urandom, $urandom);
            end else begin
                move(rand_span(256), rand_span(64), rand_span(256));
            end
        end

        // drain: wait for every move result, then watch for strays
        start <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (BOX_ENTRIES + 8) @(posedge i_clk);

        $display("%0d items sent, %0d move results checked", n_items, moves);
        $display("moves with x stopped: %0d, with z stopped: %0d", x_stops, z_stops);
        if (errors == 0 && pending == 0) begin
            $display("[aabb_slide_collision] OK");
        end else begin
            $display("[aabb_slide_collision] ERROR");
        end
        $finish;
    end

endmodule
